// ===== rtl/bpqe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpqe_pkg
// Shared constants and types for the bounded evicting priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bpqe_pkg;

    localparam int          DEF_CAPACITY = 256;
    localparam int          WORD_W       = 64;
    localparam logic [63:0] FREE_WORD    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_TAKE  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OUT_STORED  = 3'd0,
        OUT_EVICTED = 3'd1,
        OUT_REJECTED = 3'd2,
        OUT_POPPED  = 3'd3,
        OUT_NOTHING = 3'd4,
        OUT_TAKEN   = 3'd5,
        OUT_CLEARED = 3'd6
    } outcome_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_PRE,
        ST_DECIDE,
        ST_POST,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/bpqe_ram.sv =====
// ----------------------------------------------------------------------------
// bpqe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpqe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bpqe_scan.sv =====
// ----------------------------------------------------------------------------
// bpqe_scan
// Accumulates min, max, held count, free-slot candidates and the selected slot's word over one sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module bpqe_scan
    import bpqe_pkg::*;
#(
    parameter int AW = 8,
    parameter int CW = 9
) (
    input  wire logic              clk,
    input  wire logic              start,
    input  wire logic              smp_vld,
    input  wire logic [AW-1:0]     smp_idx,
    input  wire logic [63:0]       smp_data,
    input  wire logic [AW-1:0]     hint,
    input  wire logic [AW-1:0]     ring [4],
    input  wire logic [AW-1:0]     sidx,
    output logic      [63:0]       min_val,
    output logic      [AW-1:0]     min_idx,
    output logic      [63:0]       max_val,
    output logic      [AW-1:0]     max_idx,
    output logic      [CW-1:0]     held,
    output logic                   hint_free,
    output logic      [3:0]        ring_free,
    output logic                   ge_found,
    output logic      [AW-1:0]     ge_idx,
    output logic                   any_found,
    output logic      [AW-1:0]     any_idx,
    output logic      [63:0]       sidx_word
);

    logic is_fr;
    assign is_fr = (smp_data == FREE_WORD);

    // accumulators, cleared at the start of each sweep
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            min_val   <= FREE_WORD;
            min_idx   <= '0;
            max_val   <= '0;
            max_idx   <= '0;
            held      <= '0;
            hint_free <= 1'b0;
            ring_free <= '0;
            ge_found  <= 1'b0;
            ge_idx    <= '0;
            any_found <= 1'b0;
            any_idx   <= '0;
            sidx_word <= FREE_WORD;
        end
        else if (smp_vld)
        begin
            if (!is_fr)
            begin
                held <= held + 1'b1;
                if (smp_data < min_val)
                begin
                    min_val <= smp_data;
                    min_idx <= smp_idx;
                end
            end
            if (smp_data > max_val)
            begin
                max_val <= smp_data;
                max_idx <= smp_idx;
            end
            if (is_fr && smp_idx == hint)
            begin
                hint_free <= 1'b1;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (is_fr && smp_idx == ring[k])
                begin
                    ring_free[k] <= 1'b1;
                end
            end
            if (is_fr && !ge_found && smp_idx >= hint)
            begin
                ge_found <= 1'b1;
                ge_idx   <= smp_idx;
            end
            if (is_fr && !any_found)
            begin
                any_found <= 1'b1;
                any_idx   <= smp_idx;
            end
            if (smp_idx == sidx)
            begin
                sidx_word <= smp_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bounded_priority_queue_evicting_core.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_queue_evicting_core
// Fixed-capacity slot store with push/evict, pop-min, take and clear.
// ----------------------------------------------------------------------------
// For each item the single read port of the slot RAM is swept once before the
// action to find the minimum, the maximum and a free slot, and once after it to
// report best word, worst word and count. A clear item runs one write sweep
// over all slots plus the report sweep. After reset the RAM is filled with the
// free mark, during which no item is accepted. A finished result waits in the
// output register while the next item is taken.
`default_nettype none

module bounded_priority_queue_evicting_core
    import bpqe_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // word[63:0], slot_index[71:64]
    input  wire logic [1:0]   s_tuser,   // action[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [215:0] m_tdata,   // result_word[63:0], slot_used[71:64],
                                         // best_word[135:72], worst_word[199:136],
                                         // held_count[208:200], zero fill
    output logic      [2:0]   m_tuser    // outcome[2:0]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           rv_reg;
    logic [AW-1:0]  ridx_reg;
    logic [AW-1:0]  hint_reg, hint_next;
    logic [AW-1:0]  ring_reg [4];
    logic [AW-1:0]  ring_next [4];
    action_t        act_reg;
    logic [63:0]    word_reg;
    logic [7:0]     sidx8_reg;
    logic [63:0]    res_reg, res_next;
    outcome_t       oc_reg, oc_next;
    logic [AW-1:0]  used_reg, used_next;
    logic           out_v_reg;
    logic [63:0]    o_res_reg, o_best_reg, o_worst_reg;
    outcome_t       o_oc_reg;
    logic [7:0]     o_used_reg;
    logic [8:0]     o_held_reg;

    // RAM ports
    logic           we;
    logic [AW-1:0]  waddr;
    logic [63:0]    wdata;
    logic [63:0]    rdata;

    // scan results
    logic [63:0]    min_val, max_val, sidx_word;
    logic [AW-1:0]  min_idx, max_idx, ge_idx, any_idx;
    logic [CW-1:0]  held;
    logic           hint_free, ge_found, any_found;
    logic [3:0]     ring_free;
    logic           scan_start;
    logic           sweeping;
    logic           sweep_done;
    logic           sidx_ok;

    assign sweeping   = (state_reg == ST_PRE) || (state_reg == ST_POST);
    assign sweep_done = (cnt_reg == CW'(CAPACITY)) && !rv_reg;
    assign sidx_ok    = (32'(sidx8_reg) < CAPACITY);

    bpqe_ram #(
        .WIDTH (64),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rdata)
    );

    bpqe_scan #(
        .AW (AW),
        .CW (CW)
    ) u_scan (
        .clk       (clk),
        .start     (scan_start),
        .smp_vld   (rv_reg),
        .smp_idx   (ridx_reg),
        .smp_data  (rdata),
        .hint      (hint_reg),
        .ring      (ring_reg),
        .sidx      (AW'(sidx8_reg)),
        .min_val   (min_val),
        .min_idx   (min_idx),
        .max_val   (max_val),
        .max_idx   (max_idx),
        .held      (held),
        .hint_free (hint_free),
        .ring_free (ring_free),
        .ge_found  (ge_found),
        .ge_idx    (ge_idx),
        .any_found (any_found),
        .any_idx   (any_idx),
        .sidx_word (sidx_word)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WIPE:
            begin
                if (cnt_reg == CW'(CAPACITY - 1))
                begin
                    state_next = (act_reg == ACT_CLEAR) ? ST_POST : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (action_t'(s_tuser) == ACT_CLEAR) ? ST_WIPE : ST_PRE;
                end
            end
            ST_PRE:    if (sweep_done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_POST;
            ST_POST:   if (sweep_done) state_next = ST_FIN;
            ST_FIN:    if (!out_v_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // action decision and memory write
    always_comb
    begin
        logic [AW-1:0] s;
        logic          freed;
        logic [AW-1:0] fidx;
        s         = ge_found ? ge_idx : any_idx;
        freed     = 1'b0;
        fidx      = '0;
        we        = 1'b0;
        waddr     = cnt_reg[AW-1:0];
        wdata     = FREE_WORD;
        res_next  = res_reg;
        oc_next   = oc_reg;
        used_next = used_reg;
        hint_next = hint_reg;
        for (int k = 0; k < 4; k++)
        begin
            ring_next[k] = ring_reg[k];
        end
        s_tready  = 1'b0;
        cnt_next  = cnt_reg;
        scan_start = 1'b0;
        case (state_reg)
            ST_WIPE:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CAPACITY - 1))
                begin
                    cnt_next   = '0;
                    scan_start = 1'b1;
                end
                hint_next = '0;
                for (int k = 0; k < 4; k++)
                begin
                    ring_next[k] = '0;
                end
                res_next  = FREE_WORD;
                oc_next   = OUT_CLEARED;
                used_next = '0;
            end
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cnt_next   = '0;
                scan_start = 1'b1;
            end
            ST_PRE, ST_POST:
            begin
                if (cnt_reg != CW'(CAPACITY))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                cnt_next   = '0;
                scan_start = 1'b1;
                res_next   = FREE_WORD;
                oc_next    = OUT_NOTHING;
                used_next  = '0;
                case (act_reg)
                    ACT_PUSH:
                    begin
                        if (word_reg == FREE_WORD)
                        begin
                            oc_next = OUT_REJECTED;
                        end
                        else if (held != CW'(CAPACITY))
                        begin
                            if (hint_free)         s = hint_reg;
                            else if (ring_free[0]) s = ring_reg[0];
                            else if (ring_free[1]) s = ring_reg[1];
                            else if (ring_free[2]) s = ring_reg[2];
                            else if (ring_free[3]) s = ring_reg[3];
                            we        = 1'b1;
                            waddr     = s;
                            wdata     = word_reg;
                            hint_next = (32'(s) + 1 >= CAPACITY) ? '0 : s + 1'b1;
                            oc_next   = OUT_STORED;
                            used_next = s;
                        end
                        else if (word_reg >= max_val)
                        begin
                            oc_next  = OUT_REJECTED;
                            res_next = word_reg;
                        end
                        else
                        begin
                            we        = 1'b1;
                            waddr     = max_idx;
                            wdata     = word_reg;
                            oc_next   = OUT_EVICTED;
                            res_next  = max_val;
                            used_next = max_idx;
                        end
                    end
                    ACT_POP:
                    begin
                        if (held != '0)
                        begin
                            we        = 1'b1;
                            waddr     = min_idx;
                            freed     = 1'b1;
                            fidx      = min_idx;
                            oc_next   = OUT_POPPED;
                            res_next  = min_val;
                            used_next = min_idx;
                        end
                    end
                    ACT_TAKE:
                    begin
                        if (sidx_ok)
                        begin
                            used_next = AW'(sidx8_reg);
                            if (sidx_word != FREE_WORD)
                            begin
                                we       = 1'b1;
                                waddr    = AW'(sidx8_reg);
                                freed    = 1'b1;
                                fidx     = AW'(sidx8_reg);
                                oc_next  = OUT_TAKEN;
                                res_next = sidx_word;
                            end
                        end
                    end
                    default: ;
                endcase
                // a freed slot becomes the hint and lands in the ring
                if (freed)
                begin
                    hint_next = fidx;
                    ring_next[2'({2'b00, fidx})] = fidx;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            hint_reg  <= '0;
            for (int k = 0; k < 4; k++)
            begin
                ring_reg[k] <= '0;
            end
            act_reg   <= ACT_PUSH;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= sweeping && (cnt_reg != CW'(CAPACITY));
            hint_reg  <= hint_next;
            for (int k = 0; k < 4; k++)
            begin
                ring_reg[k] <= ring_next[k];
            end
            if (state_reg == ST_IDLE && s_tvalid)
            begin
                act_reg <= action_t'(s_tuser);
            end
            if (state_reg == ST_FIN && (!out_v_reg || m_tready))
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ridx_reg <= cnt_reg[AW-1:0];
        res_reg  <= res_next;
        oc_reg   <= oc_next;
        used_reg <= used_next;
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            word_reg  <= s_tdata[63:0];
            sidx8_reg <= s_tdata[71:64];
        end
        if (state_reg == ST_FIN && (!out_v_reg || m_tready))
        begin
            o_res_reg   <= res_reg;
            o_oc_reg    <= oc_reg;
            o_used_reg  <= 8'(used_reg);
            o_best_reg  <= min_val;
            o_worst_reg <= max_val;
            o_held_reg  <= 9'(held);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = o_oc_reg;
    assign m_tdata  = {7'd0, o_held_reg, o_worst_reg, o_best_reg, o_used_reg, o_res_reg};

    // checks
    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == OUT_POPPED || m_tuser == OUT_TAKEN)
            |-> m_tdata[63:0] != FREE_WORD)
        else $error("popped or taken item carries the free mark");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == OUT_CLEARED |-> m_tdata[208:200] == 9'd0)
        else $error("clear result reports held entries");

    a_ready_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !rv_reg && !we)
        else $error("item accepted while the store is being swept or written");

endmodule

`default_nettype wire

// ===== bench/bounded_priority_queue_evicting_core_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_queue_evicting_core_tb
// Drives push, pop, take and clear items into the evicting priority queue and
// checks every result, field by field, against an in-bench model of the store.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: holds its own copy of the slot store and queues predictions
class queue_scoreboard;
    localparam int SLOTS = 256;

    logic [63:0] slots [SLOTS];
    int unsigned free_cnt;
    int unsigned hint;
    int unsigned ring [4];
    logic [215:0] pending_data [$];
    logic [2:0]   pending_kind [$];
    int errors;

    function new();
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        for (int i = 0; i < SLOTS; i++) slots[i] = bpqe_pkg::FREE_WORD;
        free_cnt = SLOTS;
        hint = 0;
        for (int i = 0; i < 4; i++) ring[i] = 0;
    endfunction

    function void release_slot(int unsigned idx);
        hint = idx;
        ring[idx & 3] = idx;
        if (free_cnt < SLOTS) free_cnt++;
    endfunction

    // hint first, then recently freed slots, then wrapping scan from the hint
    function int find_open();
        int unsigned j;
        if (slots[hint] == bpqe_pkg::FREE_WORD) return hint;
        for (int k = 0; k < 4; k++)
            if (slots[ring[k]] == bpqe_pkg::FREE_WORD) return ring[k];
        for (int k = 0; k < SLOTS; k++) begin
            j = (hint + k) % SLOTS;
            if (slots[j] == bpqe_pkg::FREE_WORD) return j;
        end
        return -1;
    endfunction

    function void note_item(bpqe_pkg::action_t act, logic [63:0] word, logic [7:0] sidx);
        logic [63:0] res, best, worst, wv;
        bpqe_pkg::outcome_t oc;
        logic [7:0] used;
        int unsigned held, wi, bi;
        int f;
        bit found;
        res = bpqe_pkg::FREE_WORD;
        oc = bpqe_pkg::OUT_NOTHING;
        used = 0;
        held = 0;
        case (act)
            bpqe_pkg::ACT_PUSH: begin
                if (word == bpqe_pkg::FREE_WORD) oc = bpqe_pkg::OUT_REJECTED;
                else begin
                    f = find_open();
                    if (f >= 0) begin
                        slots[f] = word;
                        hint = (f + 1 >= SLOTS) ? 0 : f + 1;
                        if (free_cnt > 0) free_cnt--;
                        oc = bpqe_pkg::OUT_STORED;
                        used = f[7:0];
                    end else begin
                        wi = 0;
                        wv = slots[0];
                        for (int i = 1; i < SLOTS; i++)
                            if (slots[i] > wv) begin wv = slots[i]; wi = i; end
                        if (word >= wv) begin
                            oc = bpqe_pkg::OUT_REJECTED;
                            res = word;
                        end else begin
                            slots[wi] = word;
                            oc = bpqe_pkg::OUT_EVICTED;
                            res = wv;
                            used = wi[7:0];
                        end
                    end
                end
            end
            bpqe_pkg::ACT_POP: begin
                found = 0;
                bi = 0;
                wv = bpqe_pkg::FREE_WORD;
                for (int i = 0; i < SLOTS; i++)
                    if (slots[i] != bpqe_pkg::FREE_WORD && (!found || slots[i] < wv)) begin
                        wv = slots[i]; bi = i; found = 1;
                    end
                if (found) begin
                    slots[bi] = bpqe_pkg::FREE_WORD;
                    release_slot(bi);
                    oc = bpqe_pkg::OUT_POPPED;
                    res = wv;
                    used = bi[7:0];
                end
            end
            bpqe_pkg::ACT_TAKE: begin
                used = sidx;
                if (slots[sidx] != bpqe_pkg::FREE_WORD) begin
                    res = slots[sidx];
                    slots[sidx] = bpqe_pkg::FREE_WORD;
                    release_slot(sidx);
                    oc = bpqe_pkg::OUT_TAKEN;
                end
            end
            default: begin
                wipe();
                oc = bpqe_pkg::OUT_CLEARED;
            end
        endcase
        best = bpqe_pkg::FREE_WORD;
        worst = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slots[i] != bpqe_pkg::FREE_WORD) begin
                held++;
                if (slots[i] < best) best = slots[i];
            end
            if (slots[i] > worst) worst = slots[i];
        end
        pending_data.push_back({7'd0, held[8:0], worst, best, used, res});
        pending_kind.push_back(oc);
    endfunction

    function void check_result(logic [215:0] d, logic [2:0] k);
        logic [215:0] e;
        logic [2:0] ek;
        if (pending_data.size() == 0) begin
            $error("unexpected result item: data=%h outcome=%0d", d, k);
            errors++;
            return;
        end
        e = pending_data.pop_front();
        ek = pending_kind.pop_front();
        if (k !== ek) begin
            $error("outcome: expected %0d, got %0d", ek, k); errors++;
        end
        if (d[63:0] !== e[63:0]) begin
            $error("result_word: expected %h, got %h", e[63:0], d[63:0]); errors++;
        end
        if (d[71:64] !== e[71:64]) begin
            $error("slot_used: expected %0d, got %0d", e[71:64], d[71:64]); errors++;
        end
        if (d[135:72] !== e[135:72]) begin
            $error("best_word: expected %h, got %h", e[135:72], d[135:72]); errors++;
        end
        if (d[199:136] !== e[199:136]) begin
            $error("worst_word: expected %h, got %h", e[199:136], d[199:136]); errors++;
        end
        if (d[208:200] !== e[208:200]) begin
            $error("held_count: expected %0d, got %0d", e[208:200], d[208:200]); errors++;
        end
    endfunction
endclass

module bounded_priority_queue_evicting_core_tb;
    import bpqe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [215:0] m_tdata;
    logic [2:0]   m_tuser;

    queue_scoreboard board;
    bit calm;       // no idling on either side while set

    bounded_priority_queue_evicting_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Send one item; random gaps before it unless in a calm stretch.
    // Valid stays up after acceptance until a gap, the next item or a drain wait.
    task automatic send_item(action_t act, logic [63:0] word, logic [7:0] sidx);
        while (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {sidx, word};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_item(act, word, sidx);
    endtask

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        case ($urandom_range(5))
            0: w = {$urandom, $urandom};
            1: w = $urandom_range(15);
            2: w = 64'hFFFF_FFFF_FFFF_FFF0 | $urandom_range(15);
            default: w = {$urandom_range(3), $urandom_range(255)};
        endcase
        return w;
    endfunction

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (board.pending_data.size() != 0) @(posedge clk);
    endtask

    // Result side: random stalls, checks every accepted result
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    initial begin
        board = new();
        calm = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_PUSH;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edge words, all actions and corner cases
        send_item(ACT_POP, 64'd0, 8'd0);                     // pop on empty
        send_item(ACT_TAKE, 64'd0, 8'd5);                    // take free slot
        send_item(ACT_PUSH, FREE_WORD, 8'd0);                // reserved word
        send_item(ACT_PUSH, 64'd0, 8'hFF);
        send_item(ACT_PUSH, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0);
        send_item(ACT_PUSH, 64'h5555_AAAA_5555_AAAA, 8'd0);
        send_item(ACT_PUSH, 64'hAAAA_5555_AAAA_5555, 8'd0);
        send_item(ACT_TAKE, 64'd0, 8'd1);
        send_item(ACT_TAKE, 64'd0, 8'd255);
        send_item(ACT_POP, 64'd0, 8'd0);
        send_item(ACT_PUSH, 64'd7, 8'd0);
        send_item(ACT_CLEAR, 64'd0, 8'd0);
        // fill the store, then evict and reject
        calm = 1;
        for (int i = 0; i < 256; i++) send_item(ACT_PUSH, 64'd1000 + i, 8'd0);
        send_item(ACT_PUSH, 64'd5, 8'd0);                    // evicts largest
        send_item(ACT_PUSH, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0);  // rejected when full
        send_item(ACT_PUSH, 64'd1254, 8'd0);                 // equal to largest
        send_item(ACT_PUSH, FREE_WORD, 8'd0);
        for (int i = 0; i < 6; i++) send_item(ACT_TAKE, 64'd0, 8'($urandom_range(255)));
        calm = 0;
        // hold off until every result is back
        drain_wait();
        send_item(ACT_CLEAR, 64'd0, 8'd0);

        // Random part: mostly pushes and pops, some takes, rare clears
        for (int n = 0; n < 170; n++) begin
            int unsigned r;
            calm = (n >= 40 && n < 90);
            r = $urandom_range(99);
            if (r < 50) send_item(ACT_PUSH, rand_word(), 8'($urandom));
            else if (r < 75) send_item(ACT_POP, rand_word(), 8'($urandom));
            else if (r < 98) send_item(ACT_TAKE, rand_word(), 8'($urandom));
            else send_item(ACT_CLEAR, rand_word(), 8'($urandom));
            // once, fill to capacity so eviction paths are exercised
            if (n == 100) begin
                for (int i = 0; i < 256; i++) send_item(ACT_PUSH, rand_word(), 8'd0);
            end
        end
        calm = 0;
        drain_wait();
        repeat (1200) @(posedge clk);
        if (board.errors == 0 && board.pending_data.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: ~700 items, with ample margin
    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
